// ===== src/mlfq_priority_update_engine_defines.svh =====
// Assertion macros used by the scheduler engine controller.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef MLFQ_PRIORITY_UPDATE_ENGINE_DEFINES_SVH
`define MLFQ_PRIORITY_UPDATE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MLFQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MLFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mlfq_pkg.sv =====
// Package for the scheduler engine: datapath command codes, register indexes,
// field widths and the command and status structs. No dependencies.
`default_nettype none

package mlfq_pkg;

    // Fixed field widths of the request and result ports.
    localparam int SLOT_W   = 4;
    localparam int NICE_W   = 6;
    localparam int RC_W     = 32;
    localparam int READY_W  = 5;
    localparam int PRIO_W   = 6;
    localparam int LA_OUT_W = 31;
    localparam int TPS_W    = 10;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SCHED_EN     = 2'd0;
    localparam t_cfg_idx CFG_TICKS_PER_SEC = 2'd1;
    localparam t_cfg_idx CFG_PRIO_MAX     = 2'd2;
    localparam t_cfg_idx CFG_PRIO_MIN     = 2'd3;

    // Datapath operation codes.
    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_SET       = 4'd1;
    localparam t_op OP_TICK      = 4'd2;
    localparam t_op OP_LA_MUL    = 4'd3;
    localparam t_op OP_LA_ADD    = 4'd4;
    localparam t_op OP_DIV_START = 4'd5;
    localparam t_op OP_DIV_STEP  = 4'd6;
    localparam t_op OP_DIV_END   = 4'd7;
    localparam t_op OP_DECAY_MUL = 4'd8;
    localparam t_op OP_DECAY_WR  = 4'd9;
    localparam t_op OP_INC_RD    = 4'd10;
    localparam t_op OP_INC_WR    = 4'd11;
    localparam t_op OP_EMIT_PRI  = 4'd12;
    localparam t_op OP_EMIT_SUM  = 4'd13;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_op  op;
        logic out_hold;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sched_en;
        logic second;
        logic fourth;
        logic run_idle;
        logic run_ok;
        logic live;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== src/mlfq_dpath.sv =====
// Datapath of the scheduler engine: configuration, tick counters, load average,
// slot memory, shared multiplier, serial divider and result register. Uses mlfq_pkg.
`default_nettype none

module mlfq_dpath #(
    parameter int THREAD_SLOTS  = 16,
    parameter int FRACTION_BITS = 14
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mlfq_pkg::t_cmd                      i_cmd,
    input  wire logic [$clog2(THREAD_SLOTS)-1:0]     i_idx,
    output mlfq_pkg::t_status                        o_status,
    // Configuration write port.
    input  wire logic                                i_cfg_valid,
    input  wire mlfq_pkg::t_cfg_idx                  i_cfg_index,
    input  wire logic [mlfq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Request payload.
    input  wire logic [mlfq_pkg::SLOT_W-1:0]         i_slot,
    input  wire logic                                i_slot_live,
    input  wire logic signed [mlfq_pkg::NICE_W-1:0]  i_slot_nice,
    input  wire logic signed [mlfq_pkg::RC_W-1:0]    i_slot_recent_cpu,
    input  wire logic [mlfq_pkg::SLOT_W-1:0]         i_running_slot,
    input  wire logic                                i_running_is_idle,
    input  wire logic [mlfq_pkg::READY_W-1:0]        i_ready_count,
    // Result channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_kind,
    output logic [mlfq_pkg::SLOT_W-1:0]              o_out_slot,
    output logic [mlfq_pkg::PRIO_W-1:0]              o_priority_res,
    output logic [mlfq_pkg::LA_OUT_W-1:0]            o_load_average,
    output logic                                     o_yield_request,
    output logic                                     o_last
);

    localparam int AW  = $clog2(THREAD_SLOTS);
    localparam int F   = FRACTION_BITS;
    localparam int DW  = 32 + FRACTION_BITS;
    localparam int EW  = mlfq_pkg::NICE_W + 32;
    localparam logic signed [31:0] FP_ONE = 32'(1 << FRACTION_BITS);
    localparam logic signed [31:0] FP_M1  = 32'((1 << FRACTION_BITS) - 1);
    localparam logic signed [63:0] FP_M1_64 = 64'((1 << FRACTION_BITS) - 1);
    localparam logic signed [31:0] C59 = 32'((59 << FRACTION_BITS) / 60);
    localparam logic [31:0]        C1  = 32'((1 << FRACTION_BITS) / 60);

    // Configuration registers.
    logic                              r_en;
    logic [mlfq_pkg::TPS_W-1:0]        r_tps;
    logic [mlfq_pkg::PRIO_W-1:0]       r_pmax;
    logic [mlfq_pkg::PRIO_W-1:0]       r_pmin;

    // Tick bookkeeping.
    logic [mlfq_pkg::TPS_W-1:0]        r_phase;
    logic [mlfq_pkg::TPS_W-1:0]        n_phase;
    logic [1:0]                        r_tick2;
    logic [1:0]                        n_tick2;
    logic                              r_second;
    logic                              r_fourth;
    logic [mlfq_pkg::SLOT_W-1:0]       r_run;
    logic                              r_idle;
    logic [mlfq_pkg::READY_W-1:0]      r_ready;

    // Arithmetic state.
    logic signed [31:0]                r_la;
    logic signed [63:0]                r_prod;
    logic signed [31:0]                r_coeff;
    logic [32:0]                       r_rem;
    logic [DW-1:0]                     r_quo;
    logic [31:0]                       r_dvsr;
    logic                              r_dneg;
    logic                              r_dzero;

    // Slot storage.
    logic [EW-1:0]                     r_mem [THREAD_SLOTS];
    logic [THREAD_SLOTS-1:0]           r_written;
    logic [THREAD_SLOTS-1:0]           r_live;
    logic [EW-1:0]                     r_rd;
    logic                              r_rd_w;

    // Combinational signals.
    logic                              set_ok;
    logic                              run_ok;
    logic [AW-1:0]                     set_a;
    logic [AW-1:0]                     run_a;
    logic [AW-1:0]                     rd_a;
    logic [AW-1:0]                     wr_a;
    logic                              we;
    logic [EW-1:0]                     wd;
    logic signed [mlfq_pkg::NICE_W-1:0] eff_nice;
    logic signed [31:0]                eff_rc;
    logic signed [31:0]                nice_ext;
    logic signed [31:0]                mul_a;
    logic signed [31:0]                mul_b;
    logic signed [63:0]                mul_p;
    logic signed [63:0]                p_adj;
    logic signed [63:0]                p_q;
    logic signed [31:0]                p_lo;
    logic [5:0]                        ready_n;
    logic signed [31:0]                twice;
    logic signed [31:0]                den;
    logic signed [DW-1:0]              dvd;
    logic [32:0]                       rem_sh;
    logic                              q_bit;
    logic [31:0]                       q32;
    logic signed [31:0]                rc4;
    logic signed [31:0]                pmax_s;
    logic signed [31:0]                pmin_s;
    logic signed [31:0]                x1;
    logic signed [31:0]                x2;
    logic signed [31:0]                xq;
    logic signed [31:0]                p1;
    logic signed [31:0]                p2;
    logic                              out_free;

    // Address and range checks.
    assign set_ok = ({28'd0, i_slot} < 32'(THREAD_SLOTS));
    assign run_ok = ({28'd0, r_run} < 32'(THREAD_SLOTS));
    assign set_a  = AW'(i_slot);
    assign run_a  = AW'(r_run);
    assign rd_a   = (i_cmd.op == mlfq_pkg::OP_INC_RD) ? run_a : i_idx;

    // An entry never written reads as zero.
    assign eff_nice = r_rd_w ? $signed(r_rd[EW-1:32]) : '0;
    assign eff_rc   = r_rd_w ? $signed(r_rd[31:0]) : '0;
    assign nice_ext = 32'(eff_nice);

    // Shared signed multiplier and truncation toward zero by 2^F.
    assign mul_a = (i_cmd.op == mlfq_pkg::OP_LA_MUL) ? r_la : r_coeff;
    assign mul_b = (i_cmd.op == mlfq_pkg::OP_LA_MUL) ? C59 : eff_rc;
    assign mul_p = 64'(mul_a) * 64'(mul_b);
    assign p_adj = r_prod + (r_prod[63] ? FP_M1_64 : 64'sd0);
    assign p_q   = p_adj >>> F;
    assign p_lo  = p_q[31:0];

    // Ready threads plus the running one when it is not idle.
    assign ready_n = 6'(r_ready) + 6'(!r_idle);

    // Divider operands for the decay coefficient.
    assign twice = r_la <<< 1;
    assign den   = twice + FP_ONE;
    assign dvd   = {twice, {F{1'b0}}};
    assign rem_sh = {r_rem[31:0], r_quo[DW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_dvsr});
    assign q32    = r_quo[31:0];

    // Priority from the entry read at the current slot.
    assign rc4    = (eff_rc + (eff_rc[31] ? 32'sd3 : 32'sd0)) >>> 2;
    assign pmax_s = $signed({26'd0, r_pmax});
    assign pmin_s = $signed({26'd0, r_pmin});
    assign x1     = (pmax_s <<< F) - rc4;
    assign x2     = x1 - (nice_ext <<< (F + 1));
    assign xq     = (x2 + (x2[31] ? FP_M1 : 32'sd0)) >>> F;
    assign p1     = (xq > pmax_s) ? pmax_s : xq;
    assign p2     = (p1 < pmin_s) ? pmin_s : p1;

    // Memory write selection.
    always_comb begin
        we   = 1'b0;
        wr_a = i_idx;
        wd   = {eff_nice, p_lo + (nice_ext <<< F)};
        case (i_cmd.op)
            mlfq_pkg::OP_SET: begin
                we   = set_ok;
                wr_a = set_a;
                wd   = {i_slot_nice, i_slot_recent_cpu};
            end
            mlfq_pkg::OP_DECAY_WR: begin
                we = 1'b1;
            end
            mlfq_pkg::OP_INC_WR: begin
                we   = 1'b1;
                wr_a = run_a;
                wd   = {eff_nice, eff_rc + FP_ONE};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Slot memory with registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_a] <= wd;
        end
        r_rd <= r_mem[rd_a];
    end

    // Written and live marks per slot, plus the read-side written mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_live    <= '0;
            r_rd_w    <= 1'b0;
        end else begin
            if (we) begin
                r_written[wr_a] <= 1'b1;
            end
            if (i_cmd.op == mlfq_pkg::OP_SET && set_ok) begin
                r_live[set_a] <= i_slot_live;
            end
            r_rd_w <= r_written[rd_a];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b0;
            r_tps  <= 10'd100;
            r_pmax <= 6'd63;
            r_pmin <= 6'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mlfq_pkg::CFG_SCHED_EN:      r_en   <= i_cfg_data[0];
                mlfq_pkg::CFG_TICKS_PER_SEC: r_tps  <= i_cfg_data;
                mlfq_pkg::CFG_PRIO_MAX:      r_pmax <= i_cfg_data[5:0];
                mlfq_pkg::CFG_PRIO_MIN:      r_pmin <= i_cfg_data[5:0];
                default:                     r_en   <= r_en;
            endcase
        end
    end

    // Tick counters, the second and fourth-tick flags and the load average.
    assign n_phase = r_phase + 10'd1;
    assign n_tick2 = r_tick2 + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_tick2  <= '0;
            r_second <= 1'b0;
            r_fourth <= 1'b0;
            r_la     <= '0;
        end else begin
            if (i_cmd.op == mlfq_pkg::OP_TICK) begin
                r_tick2  <= n_tick2;
                r_fourth <= (n_tick2 == 2'd0);
                r_second <= (n_phase >= r_tps);
                r_phase  <= (n_phase >= r_tps) ? '0 : n_phase;
            end
            if (i_cmd.op == mlfq_pkg::OP_LA_ADD) begin
                r_la <= p_lo + $signed(C1 * {26'd0, ready_n});
            end
        end
    end

    // Tick payload is captured when the tick is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mlfq_pkg::OP_TICK) begin
            r_run   <= i_running_slot;
            r_idle  <= i_running_is_idle;
            r_ready <= i_ready_count;
        end
    end

    // Product register and the restoring divider.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mlfq_pkg::OP_LA_MUL, mlfq_pkg::OP_DECAY_MUL: begin
                r_prod <= mul_p;
            end
            mlfq_pkg::OP_DIV_START: begin
                r_rem   <= '0;
                r_quo   <= twice[31] ? DW'(-dvd) : DW'(dvd);
                r_dvsr  <= den[31] ? 32'(-den) : 32'(den);
                r_dneg  <= twice[31] ^ den[31];
                r_dzero <= (den == 32'sd0);
            end
            mlfq_pkg::OP_DIV_STEP: begin
                r_rem <= q_bit ? (rem_sh - {1'b0, r_dvsr}) : rem_sh;
                r_quo <= {r_quo[DW-2:0], q_bit};
            end
            mlfq_pkg::OP_DIV_END: begin
                r_coeff <= r_dzero ? 32'sd0 : (r_dneg ? $signed(-q32) : $signed(q32));
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    // Result register: loads on an emit command, clears when taken.
    assign out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == mlfq_pkg::OP_EMIT_PRI || i_cmd.op == mlfq_pkg::OP_EMIT_SUM) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mlfq_pkg::OP_EMIT_PRI) begin
            o_kind          <= 1'b1;
            o_out_slot      <= mlfq_pkg::SLOT_W'(i_idx);
            o_priority_res  <= p2[5:0];
            o_load_average  <= r_la[30:0];
            o_yield_request <= 1'b1;
            o_last          <= 1'b0;
        end else if (i_cmd.op == mlfq_pkg::OP_EMIT_SUM) begin
            o_kind          <= 1'b0;
            o_out_slot      <= '0;
            o_priority_res  <= '0;
            o_load_average  <= r_la[30:0];
            o_yield_request <= r_en & r_fourth;
            o_last          <= 1'b1;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.sched_en = r_en;
        o_status.second   = r_second;
        o_status.fourth   = r_fourth;
        o_status.run_idle = r_idle;
        o_status.run_ok   = run_ok;
        o_status.live     = r_live[i_idx];
        o_status.out_free = out_free && !i_cmd.out_hold;
    end

endmodule

`default_nettype wire

// ===== src/mlfq_ctrl.sv =====
// Controller of the scheduler engine: sequences a tick through the load average,
// divider, decay, increment and priority passes. Uses mlfq_pkg and the defines header.
`default_nettype none
`include "mlfq_priority_update_engine_defines.svh"

module mlfq_ctrl #(
    parameter int THREAD_SLOTS  = 16,
    parameter int FRACTION_BITS = 14
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_req_type,
    output logic                                  o_in_stall,
    input  wire mlfq_pkg::t_status                i_status,
    output mlfq_pkg::t_cmd                        o_cmd,
    output logic [$clog2(THREAD_SLOTS)-1:0]       o_idx
);

    localparam int AW = $clog2(THREAD_SLOTS);
    localparam int DW = 32 + FRACTION_BITS;
    localparam int CW = $clog2(DW);
    localparam logic [AW-1:0] IDX_LAST = AW'(THREAD_SLOTS - 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_LA_MUL  = 4'd2;
    localparam logic [3:0] S_LA_ADD  = 4'd3;
    localparam logic [3:0] S_DIV_ST  = 4'd4;
    localparam logic [3:0] S_DIV     = 4'd5;
    localparam logic [3:0] S_DIV_END = 4'd6;
    localparam logic [3:0] S_DC_RD   = 4'd7;
    localparam logic [3:0] S_DC_MUL  = 4'd8;
    localparam logic [3:0] S_DC_WR   = 4'd9;
    localparam logic [3:0] S_INC_RD  = 4'd10;
    localparam logic [3:0] S_INC_WR  = 4'd11;
    localparam logic [3:0] S_PR_RD   = 4'd12;
    localparam logic [3:0] S_PR_EM   = 4'd13;
    localparam logic [3:0] S_SUM     = 4'd14;

    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    assign o_idx      = r_idx;
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and command.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        o_cmd.op     = mlfq_pkg::OP_NONE;
        o_cmd.out_hold = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type) begin
                        o_cmd.op = mlfq_pkg::OP_SET;
                    end else begin
                        o_cmd.op = mlfq_pkg::OP_TICK;
                        n_state  = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (!i_status.sched_en) begin
                    n_state = S_SUM;
                end else if (i_status.second) begin
                    n_state = S_LA_MUL;
                end else begin
                    n_state = S_INC_RD;
                end
            end
            S_LA_MUL: begin
                o_cmd.op = mlfq_pkg::OP_LA_MUL;
                n_state  = S_LA_ADD;
            end
            S_LA_ADD: begin
                o_cmd.op = mlfq_pkg::OP_LA_ADD;
                n_state  = S_DIV_ST;
            end
            S_DIV_ST: begin
                o_cmd.op = mlfq_pkg::OP_DIV_START;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = mlfq_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd.op = mlfq_pkg::OP_DIV_END;
                n_idx    = '0;
                n_state  = S_DC_RD;
            end
            S_DC_RD: begin
                if (i_status.live) begin
                    n_state = S_DC_MUL;
                end else if (r_idx == IDX_LAST) begin
                    n_state = S_INC_RD;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DC_MUL: begin
                o_cmd.op = mlfq_pkg::OP_DECAY_MUL;
                n_state  = S_DC_WR;
            end
            S_DC_WR: begin
                o_cmd.op = mlfq_pkg::OP_DECAY_WR;
                if (r_idx == IDX_LAST) begin
                    n_state = S_INC_RD;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_DC_RD;
                end
            end
            S_INC_RD: begin
                n_idx = '0;
                if (!i_status.run_idle && i_status.run_ok) begin
                    o_cmd.op = mlfq_pkg::OP_INC_RD;
                    n_state  = S_INC_WR;
                end else if (i_status.fourth) begin
                    n_state = S_PR_RD;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_INC_WR: begin
                o_cmd.op = mlfq_pkg::OP_INC_WR;
                n_state  = i_status.fourth ? S_PR_RD : S_SUM;
            end
            S_PR_RD: begin
                if (i_status.live) begin
                    n_state = S_PR_EM;
                end else if (r_idx == IDX_LAST) begin
                    n_state = S_SUM;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_PR_EM: begin
                if (i_status.out_free) begin
                    o_cmd.op = mlfq_pkg::OP_EMIT_PRI;
                    if (r_idx == IDX_LAST) begin
                        n_state = S_SUM;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_PR_RD;
                    end
                end
            end
            S_SUM: begin
                if (i_status.out_free) begin
                    o_cmd.op = mlfq_pkg::OP_EMIT_SUM;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

    // A result is only loaded when the result register can take it.
    `MLFQ_ASSERT_NOW(a_emit_free, (o_cmd.op == mlfq_pkg::OP_EMIT_PRI || o_cmd.op == mlfq_pkg::OP_EMIT_SUM), i_status.out_free, "emit while result register busy")
    // The summary closes a tick and frees the request side.
    `MLFQ_ASSERT_NEXT(a_sum_idle, (o_cmd.op == mlfq_pkg::OP_EMIT_SUM), (r_state == S_IDLE && !o_in_stall), "no return to idle after summary")
    // The divider runs only inside its own window.
    `MLFQ_ASSERT_NOW(a_div_win, (o_cmd.op == mlfq_pkg::OP_DIV_STEP), (r_state == S_DIV && r_cnt <= CNT_LAST), "divider step outside its window")

endmodule

`default_nettype wire

// ===== src/mlfq_priority_update_engine.sv =====
// Scheduler bookkeeping engine: load average, recent cpu and priority per slot.
// Set-slot request: stores the slot entry, no result. Tick request: with scheduling
// off only the summary; on a second boundary the load average, the divider and a
// decay pass over the live slots; then the increment of the running slot unless
// idle; on a fourth tick a priority per live slot, longer while results stall.
// Synchronous active-low reset clears control state and all slot marks.
`default_nettype none

module mlfq_priority_update_engine #(
    parameter int THREAD_SLOTS  = 16,
    parameter int FRACTION_BITS = 14
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Request channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_req_type,
    input  wire logic [mlfq_pkg::SLOT_W-1:0]         i_slot,
    input  wire logic                                i_slot_live,
    input  wire logic signed [mlfq_pkg::NICE_W-1:0]  i_slot_nice,
    input  wire logic signed [mlfq_pkg::RC_W-1:0]    i_slot_recent_cpu,
    input  wire logic [mlfq_pkg::SLOT_W-1:0]         i_running_slot,
    input  wire logic                                i_running_is_idle,
    input  wire logic [mlfq_pkg::READY_W-1:0]        i_ready_count,
    // Result channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_kind,
    output logic [mlfq_pkg::SLOT_W-1:0]              o_out_slot,
    output logic [mlfq_pkg::PRIO_W-1:0]              o_priority_res,
    output logic [mlfq_pkg::LA_OUT_W-1:0]            o_load_average,
    output logic                                     o_yield_request,
    output logic                                     o_last,
    // Configuration write channel.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire mlfq_pkg::t_cfg_idx                  i_cfg_index,
    input  wire logic [mlfq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(THREAD_SLOTS);

    mlfq_pkg::t_cmd    cmd;
    mlfq_pkg::t_status status;
    logic [AW-1:0]     idx;
    logic              cfg_we;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    mlfq_ctrl #(
        .THREAD_SLOTS  (THREAD_SLOTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    mlfq_dpath #(
        .THREAD_SLOTS  (THREAD_SLOTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_idx             (idx),
        .o_status          (status),
        .i_cfg_valid       (cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_slot            (i_slot),
        .i_slot_live       (i_slot_live),
        .i_slot_nice       (i_slot_nice),
        .i_slot_recent_cpu (i_slot_recent_cpu),
        .i_running_slot    (i_running_slot),
        .i_running_is_idle (i_running_is_idle),
        .i_ready_count     (i_ready_count),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_out_slot        (o_out_slot),
        .o_priority_res    (o_priority_res),
        .o_load_average    (o_load_average),
        .o_yield_request   (o_yield_request),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire
